// ===== design/cdh_pkg.sv =====
// Shared types and constants for the canonical Huffman bit decoder.
// No dependencies; imported by the front, engine, top level and checker.
`default_nettype none
package cdh_pkg;

  localparam int unsigned DefMaxSymbols  = 288;
  localparam int unsigned DefMaxCodeBits = 15;

  // Fixed port and walk-register widths
  localparam int unsigned LenInW  = 8;
  localparam int unsigned SymOutW = 9;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned FirstW  = 17;

  typedef enum logic [2:0] {
    ST_SYMBOL   = 3'd0,
    ST_INVALID  = 3'd1,
    ST_ACCEPT   = 3'd2,
    ST_REJECT   = 3'd3,
    ST_NOTREADY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_LEN,
    KIND_LEN_LAST,
    KIND_BIT
  } kind_e;

  // Classified input item as it sits in the front queue
  typedef struct packed {
    kind_e             kind;
    logic              bad;
    logic [LenInW-1:0] len;
    logic              bit_val;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [SymOutW-1:0] symbol;
  } result_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_KRAFT,
    ENG_BUILD,
    ENG_DRAIN,
    ENG_SYM
  } eng_state_e;

endpackage
`default_nettype wire

// ===== design/cdh_fifo.sv =====
// Two-entry queue used between front and engine and for results.
// Depends on nothing but its Width parameter.
`default_nettype none
module cdh_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/cdh_front.sv =====
// Front end: classifies incoming items and queues them for the engine.
// Uses cdh_pkg and cdh_fifo.
`default_nettype none
module cdh_front
  import cdh_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = DefMaxCodeBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              req_type_i,
  input  wire logic [LenInW-1:0] code_length_i,
  input  wire logic              last_length_i,
  input  wire logic              bit_req_i,
  output item_t                  item_o,
  output logic                   item_valid_o,
  input  wire logic              item_take_i
);

  item_t                    item_in;
  logic [$bits(item_t)-1:0] q_rdata;
  logic                     q_empty;

  // classify: kind, and whether a length is out of range
  always_comb begin
    if (req_type_i) begin
      item_in.kind = KIND_BIT;
    end else if (last_length_i) begin
      item_in.kind = KIND_LEN_LAST;
    end else begin
      item_in.kind = KIND_LEN;
    end
    item_in.bad     = !req_type_i && (code_length_i > LenInW'(MAX_CODE_BITS));
    item_in.len     = code_length_i;
    item_in.bit_val = bit_req_i;
  end

  cdh_fifo #(
    .Width($bits(item_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(item_in),
    .full_o (full_o),
    .pop_i  (item_take_i),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign item_o       = item_t'(q_rdata);
  assign item_valid_o = !q_empty;

endmodule
`default_nettype wire

// ===== design/cdh_engine.sv =====
// Back end: table loader, Kraft check, table build and bit-serial code walk.
// Uses cdh_pkg; holds the length store and the symbol table memories.
`default_nettype none
module cdh_engine
  import cdh_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS   = DefMaxSymbols,
  parameter int unsigned MAX_CODE_BITS = DefMaxCodeBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  item_t      item_i,
  input  wire logic  item_valid_i,
  output logic       item_take_o,
  output result_t    res_o,
  output logic       res_push_o,
  input  wire logic  res_full_i
);

  localparam int unsigned AW = $clog2(MAX_SYMBOLS);
  localparam int unsigned PW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned LW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned KW = MAX_CODE_BITS + CW + 1;
  localparam int unsigned IW = FirstW + 1;

  eng_state_e state_q, state_d;

  logic [PW-1:0]     load_pos_q, load_pos_d;
  logic [PW-1:0]     loaded_q, loaded_d;
  logic              bad_q, bad_d;
  logic              rej_q, rej_d;
  logic              valid_q, valid_d;
  logic [LW-1:0]     bits_q, bits_d;
  logic [CodeW-1:0]  partial_q, partial_d;
  logic [FirstW-1:0] first_q, first_d;
  logic [CW-1:0]     offset_q, offset_d;
  logic [CW-1:0]     counts_q [MAX_CODE_BITS+1];
  logic [CW-1:0]     counts_d [MAX_CODE_BITS+1];
  logic [LW-1:0]     b_q, b_d;
  logic [KW-1:0]     kraft_q, kraft_d;
  logic [PW-1:0]     scan_q, scan_d;
  logic [AW-1:0]     k_q, k_d;
  logic              pipe_vld_q, pipe_vld_d;
  logic [AW-1:0]     pipe_sym_q, pipe_sym_d;
  logic [LW-1:0]     pipe_b_q, pipe_b_d;
  logic              idx_ok_q, idx_ok_d;

  // memories
  logic [LW-1:0] len_mem [MAX_SYMBOLS];
  logic [AW-1:0] sym_mem [MAX_SYMBOLS];
  logic          len_we, len_re, sym_we, sym_re;
  logic [AW-1:0] len_waddr, len_raddr, sym_waddr, sym_raddr;
  logic [LW-1:0] len_wdata, len_rdata_q;
  logic [AW-1:0] sym_wdata, sym_rdata_q;

  // shared count read port
  logic [LW-1:0] cnt_idx;
  logic [CW-1:0] cnt_rd;

  // decode datapath
  logic              take;
  logic [CodeW-1:0]  code;
  logic [FirstW-1:0] code_x, diff;
  logic [IW-1:0]     idx_sum;
  logic              hit;
  logic [LW-1:0]     n_bits;
  logic              used;
  logic [KW-1:0]     kraft_sum;
  logic              len_hit;

  assign take    = (state_q == ENG_IDLE) && item_valid_i && !res_full_i;
  assign n_bits  = bits_q + LW'(1);
  assign cnt_idx = (state_q == ENG_KRAFT) ? b_q : n_bits;
  assign cnt_rd  = counts_q[cnt_idx];

  assign code    = partial_q | CodeW'(item_i.bit_val);
  assign code_x  = FirstW'(code);
  assign diff    = code_x - first_q;
  assign hit     = (code_x >= first_q) && (diff < FirstW'(cnt_rd));
  assign idx_sum = IW'(offset_q) + IW'(diff);

  assign kraft_sum = kraft_q + (KW'(cnt_rd) << (LW'(MAX_CODE_BITS) - b_q));
  assign len_hit   = pipe_vld_q && (len_rdata_q == pipe_b_q);

  // any length used in the loaded table
  always_comb begin
    used = 1'b0;
    for (int i = 1; i <= int'(MAX_CODE_BITS); i++) begin
      used = used | (counts_q[i] != '0);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: begin
        if (take) begin
          if (item_i.kind == KIND_LEN_LAST) begin
            state_d = ENG_KRAFT;
          end else if (item_i.kind == KIND_BIT && valid_q && hit) begin
            state_d = ENG_SYM;
          end
        end
      end
      ENG_KRAFT: begin
        if (b_q == LW'(MAX_CODE_BITS)) begin
          if (rej_q || !used || (kraft_sum > (KW'(1) << MAX_CODE_BITS))) begin
            state_d = ENG_IDLE;
          end else begin
            state_d = ENG_BUILD;
          end
        end
      end
      ENG_BUILD: begin
        if (scan_q == loaded_q - PW'(1) && b_q == LW'(MAX_CODE_BITS)) begin
          state_d = ENG_DRAIN;
        end
      end
      ENG_DRAIN: state_d = ENG_IDLE;
      ENG_SYM:   state_d = ENG_IDLE;
      default:   state_d = ENG_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    load_pos_d = load_pos_q;
    loaded_d   = loaded_q;
    bad_d      = bad_q;
    rej_d      = rej_q;
    valid_d    = valid_q;
    bits_d     = bits_q;
    partial_d  = partial_q;
    first_d    = first_q;
    offset_d   = offset_q;
    counts_d   = counts_q;
    b_d        = b_q;
    kraft_d    = kraft_q;
    scan_d     = scan_q;
    k_d        = k_q;
    pipe_vld_d = 1'b0;
    pipe_sym_d = pipe_sym_q;
    pipe_b_d   = pipe_b_q;
    idx_ok_d   = idx_ok_q;
    len_we     = 1'b0;
    len_waddr  = load_pos_q[AW-1:0];
    len_wdata  = item_i.bad ? '0 : item_i.len[LW-1:0];
    len_re     = 1'b0;
    len_raddr  = scan_q[AW-1:0];
    sym_we     = 1'b0;
    sym_waddr  = k_q;
    sym_wdata  = pipe_sym_q;
    sym_re     = 1'b0;
    sym_raddr  = idx_sum[AW-1:0];
    item_take_o       = take;
    res_push_o        = 1'b0;
    res_o.status      = ST_SYMBOL;
    res_o.symbol      = '0;

    unique case (state_q)
      ENG_IDLE: begin
        if (take && item_i.kind != KIND_BIT) begin
          // length item: drop any partial code, record the length
          bits_d    = '0;
          partial_d = '0;
          first_d   = '0;
          offset_d  = '0;
          valid_d   = 1'b0;
          if (load_pos_q == '0) begin
            for (int i = 0; i <= int'(MAX_CODE_BITS); i++) begin
              counts_d[i] = '0;
            end
          end
          if (load_pos_q < PW'(MAX_SYMBOLS)) begin
            len_we     = 1'b1;
            load_pos_d = load_pos_q + PW'(1);
            if (item_i.bad) begin
              bad_d = 1'b1;
            end else if (item_i.len != '0) begin
              counts_d[item_i.len[LW-1:0]] = counts_d[item_i.len[LW-1:0]] + CW'(1);
            end
          end
          if (item_i.kind == KIND_LEN_LAST) begin
            loaded_d   = load_pos_d;
            rej_d      = bad_d;
            load_pos_d = '0;
            bad_d      = 1'b0;
            b_d        = LW'(1);
            kraft_d    = '0;
          end
        end else if (take) begin
          if (!valid_q) begin
            res_push_o   = 1'b1;
            res_o.status = ST_NOTREADY;
          end else if (hit) begin
            sym_re    = 1'b1;
            idx_ok_d  = idx_sum < IW'(MAX_SYMBOLS);
            bits_d    = '0;
            partial_d = '0;
            first_d   = '0;
            offset_d  = '0;
          end else begin
            offset_d  = offset_q + cnt_rd;
            first_d   = (first_q + FirstW'(cnt_rd)) << 1;
            partial_d = code << 1;
            bits_d    = n_bits;
            if (n_bits >= LW'(MAX_CODE_BITS)) begin
              bits_d       = '0;
              partial_d    = '0;
              first_d      = '0;
              offset_d     = '0;
              res_push_o   = 1'b1;
              res_o.status = ST_INVALID;
            end
          end
        end
      end
      ENG_KRAFT: begin
        // one length per cycle into the Kraft sum
        kraft_d = kraft_sum;
        b_d     = b_q + LW'(1);
        if (b_q == LW'(MAX_CODE_BITS)) begin
          b_d    = LW'(1);
          scan_d = '0;
          k_d    = '0;
          if (state_d == ENG_IDLE) begin
            res_push_o   = 1'b1;
            res_o.status = ST_REJECT;
          end
        end
      end
      ENG_BUILD: begin
        // scan symbols for each length; compare in the cycle after the read
        len_re     = 1'b1;
        pipe_vld_d = 1'b1;
        pipe_sym_d = scan_q[AW-1:0];
        pipe_b_d   = b_q;
        if (len_hit) begin
          sym_we = 1'b1;
          k_d    = k_q + AW'(1);
        end
        if (scan_q == loaded_q - PW'(1)) begin
          scan_d = '0;
          b_d    = b_q + LW'(1);
        end else begin
          scan_d = scan_q + PW'(1);
        end
      end
      ENG_DRAIN: begin
        if (len_hit) begin
          sym_we = 1'b1;
          k_d    = k_q + AW'(1);
        end
        valid_d      = 1'b1;
        res_push_o   = 1'b1;
        res_o.status = ST_ACCEPT;
      end
      ENG_SYM: begin
        res_push_o   = 1'b1;
        res_o.status = ST_SYMBOL;
        res_o.symbol = idx_ok_q ? SymOutW'(sym_rdata_q) : '0;
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase
  end

  // control and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ENG_IDLE;
      load_pos_q <= '0;
      loaded_q   <= '0;
      bad_q      <= 1'b0;
      rej_q      <= 1'b0;
      valid_q    <= 1'b0;
      bits_q     <= '0;
      partial_q  <= '0;
      first_q    <= '0;
      offset_q   <= '0;
      b_q        <= '0;
      kraft_q    <= '0;
      scan_q     <= '0;
      k_q        <= '0;
      pipe_vld_q <= 1'b0;
      idx_ok_q   <= 1'b0;
      for (int i = 0; i <= int'(MAX_CODE_BITS); i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      loaded_q   <= loaded_d;
      bad_q      <= bad_d;
      rej_q      <= rej_d;
      valid_q    <= valid_d;
      bits_q     <= bits_d;
      partial_q  <= partial_d;
      first_q    <= first_d;
      offset_q   <= offset_d;
      b_q        <= b_d;
      kraft_q    <= kraft_d;
      scan_q     <= scan_d;
      k_q        <= k_d;
      pipe_vld_q <= pipe_vld_d;
      idx_ok_q   <= idx_ok_d;
      counts_q   <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_sym_q <= pipe_sym_d;
    pipe_b_q   <= pipe_b_d;
  end

  // length store
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rdata_q <= len_mem[len_raddr];
    end
  end

  // symbol table sorted by length, then symbol
  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    if (sym_re) begin
      sym_rdata_q <= sym_mem[sym_raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/canonical_huffman_bit_decoder.sv =====
// Top level of the canonical Huffman bit decoder.
// Uses cdh_pkg, cdh_front, cdh_engine and cdh_fifo.
//
// Queue-style ports on both sides: push/full for items, empty/pop for results.
// A coded bit that completes a code also reads the symbol table before its result.
// The marked last length item also runs the Kraft check and, when the table passes,
// builds the symbol table: the build scans the length store once per code length
// through its single read port. Two-entry queues sit on the input and result sides,
// so the block keeps taking items while results wait.
`default_nettype none
module canonical_huffman_bit_decoder
  import cdh_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS   = DefMaxSymbols,
  parameter int unsigned MAX_CODE_BITS = DefMaxCodeBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type_i,
  input  wire logic [LenInW-1:0]  code_length_i,
  input  wire logic               last_length_i,
  input  wire logic               bit_req_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status_o,
  output logic [SymOutW-1:0]      symbol_o
);

  item_t                      item;
  logic                       item_valid, item_take;
  result_t                    res, res_out;
  logic                       res_push, res_full;
  logic [$bits(result_t)-1:0] res_rdata;

  cdh_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .code_length_i(code_length_i),
    .last_length_i(last_length_i),
    .bit_req_i    (bit_req_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  cdh_engine #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue
  cdh_fifo #(
    .Width($bits(result_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_out  = result_t'(res_rdata);
  assign status_o = res_out.status;
  assign symbol_o = res_out.symbol;

endmodule
`default_nettype wire

// ===== design/cdh_checker.sv =====
// Port-level checks for canonical_huffman_bit_decoder, bound to the top level.
// Uses cdh_pkg for status codes and widths.
`default_nettype none
module cdh_checker
  import cdh_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [2:0]         status_o,
  input wire logic [SymOutW-1:0] symbol_o
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // only defined status codes leave the block
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o <= ST_NOTREADY))
    else $error("undefined status code");

  // symbol field is zero for every non-symbol result
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_SYMBOL) |-> (symbol_o == '0))
    else $error("nonzero symbol on non-symbol result");

  // a waiting result holds until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(symbol_o)))
    else $error("waiting result changed");

endmodule

bind canonical_huffman_bit_decoder cdh_checker u_cdh_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for canonical_huffman_bit_decoder: table loads and bit decoding.
// Depends on cdh_pkg and the design sources; a built-in decoder model predicts each result.
`default_nettype none
module tb_top
  import cdh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM       = 288;
  localparam int MAXBITS    = 15;
  localparam int ITEM_GOAL  = 1900;
  localparam int SETTLE_CYC = 4500;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               req_type = 1'b0;
  logic [LenInW-1:0]  code_length = '0;
  logic               last_length = 1'b0;
  logic               bit_req = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         status;
  logic [SymOutW-1:0] symbol;

  canonical_huffman_bit_decoder dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .req_type_i(req_type), .code_length_i(code_length),
    .last_length_i(last_length), .bit_req_i(bit_req),
    .empty(empty), .pop(pop), .status_o(status), .symbol_o(symbol)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [3:0] len_mem[NSYM];
  int         len_hist[MAXBITS+1];
  int         sym_map[NSYM];
  int         load_idx;
  bit         saw_bad_len;
  bit         tbl_ok;
  int         walk_bits, walk_code, walk_first, walk_off;

  result_t    pending_q[$];
  int         errors = 0;
  int         items_sent = 0;
  bit         sender_idle_on = 1'b1;
  bit         receiver_idle_on = 1'b1;
  int         receiver_hold = 0;
  logic [7:0] lens_q[$];

  function automatic void clear_walk();
    walk_bits = 0; walk_code = 0; walk_first = 0; walk_off = 0;
  endfunction

  // queue one predicted result at the tail
  function automatic void expect_result(input result_t r);
    pending_q = {pending_q, r};
  endfunction

  // Kraft check and sort by (length, symbol) at the marked entry
  function automatic bit close_table(int loaded);
    int used, kraft, k;
    used = 0; kraft = 0; k = 0;
    for (int b = 1; b <= MAXBITS; b++) begin
      used += len_hist[b];
      kraft += len_hist[b] << (MAXBITS - b);
    end
    if (saw_bad_len || used == 0 || kraft > (1 << MAXBITS)) return 1'b0;
    for (int b = 1; b <= MAXBITS; b++)
      for (int s = 0; s < loaded; s++)
        if (len_mem[s] == b && k < NSYM) begin
          sym_map[k] = s;
          k++;
        end
    return 1'b1;
  endfunction

  // Advance the model by one accepted item
  function automatic void decode_step(input logic rq, input logic [7:0] ln, input logic lst,
                                      input logic bv);
    result_t r;
    int code, n, cnt;
    r.symbol = '0;
    if (rq == 1'b0) begin
      clear_walk();
      tbl_ok = 1'b0;
      if (load_idx == 0)
        for (int b = 0; b <= MAXBITS; b++) len_hist[b] = 0;
      if (load_idx < NSYM) begin
        if (ln > MAXBITS) begin
          saw_bad_len = 1'b1;
          len_mem[load_idx] = '0;
        end else begin
          len_mem[load_idx] = ln[3:0];
          if (ln != 0) len_hist[ln]++;
        end
        load_idx++;
      end
      if (!lst) return;
      tbl_ok = close_table(load_idx);
      load_idx = 0;
      saw_bad_len = 1'b0;
      r.status = tbl_ok ? ST_ACCEPT : ST_REJECT;
      expect_result(r);
      return;
    end
    if (!tbl_ok) begin
      r.status = ST_NOTREADY;
      expect_result(r);
      return;
    end
    code = walk_code | bv;
    n = walk_bits + 1;
    cnt = (n <= MAXBITS) ? len_hist[n] : 0;
    if (code >= walk_first && code - walk_first < cnt) begin
      r.status = ST_SYMBOL;
      r.symbol = SymOutW'(sym_map[walk_off + code - walk_first]);
      clear_walk();
      expect_result(r);
      return;
    end
    walk_off += cnt;
    walk_first = ((walk_first + cnt) << 1) & 32'h1FFFF;
    walk_code = (code << 1) & 32'hFFFF;
    walk_bits = n;
    if (walk_bits >= MAXBITS) begin
      clear_walk();
      r.status = ST_INVALID;
      expect_result(r);
    end
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Send one item; push stays high after the transfer until the next call decides
  task automatic send_item(input logic rq, input logic [7:0] ln, input logic lst,
                           input logic bv);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    code_length <= ln;
    last_length <= lst;
    bit_req <= bv;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_step(rq, ln, lst, bv);
    items_sent++;
  endtask

  task automatic send_bit(input logic bv);
    send_item(1'b1, 8'($urandom), 1'($urandom), bv);
  endtask

  task automatic wait_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Length list with Kraft sum at most one; lengths start at most maxl and grow to fit
  task automatic make_lengths(input int n, input int maxl, input bit sparse);
    int budget, ln;
    bit any;
    lens_q.delete();
    budget = 1 << MAXBITS;
    any = 1'b0;
    for (int i = 0; i < n; i++) begin
      ln = 0;
      if (!(sparse && $urandom_range(0, 3) == 0)) begin
        ln = $urandom_range(1, maxl);
        while (ln <= MAXBITS && (1 << (MAXBITS - ln)) > budget) ln++;
        if (ln > MAXBITS) ln = 0;
        else budget -= 1 << (MAXBITS - ln);
      end
      if (ln != 0) any = 1'b1;
      lens_q = {lens_q, 8'(ln)};
    end
    if (!any) lens_q[0] = 8'd15;
  endtask

  task automatic load_lengths();
    foreach (lens_q[i]) send_item(1'b0, lens_q[i], i == lens_q.size() - 1, 1'($urandom));
  endtask

  task automatic random_bits(input int n);
    repeat (n) send_bit(1'($urandom));
  endtask

  // ---------------- tests ----------------
  task automatic test_not_ready();
    send_bit(1'b0);
    send_bit(1'b1);
  endtask

  task automatic test_small_tables();
    lens_q = '{8'd1, 8'd1};
    load_lengths();
    send_bit(1'b0); send_bit(1'b1);
    // only code "0" exists: a run of ones ends as an invalid code
    lens_q = '{8'd1, 8'd0};
    load_lengths();
    repeat (MAXBITS) send_bit(1'b1);
    send_bit(1'b0);
  endtask

  task automatic test_rejects();
    lens_q = '{8'd0, 8'd0, 8'd0};        // no symbol used
    load_lengths();
    send_bit(1'b1);                       // table invalid now
    lens_q = '{8'd1, 8'd255, 8'd1};       // length above limit
    load_lengths();
    lens_q = '{8'd1, 8'd1, 8'd1};         // Kraft sum above one
    load_lengths();
    lens_q = '{8'd15, 8'd16};
    load_lengths();
  endtask

  task automatic test_abort_and_long();
    lens_q = '{8'd1, 8'd15, 8'd15, 8'd2};
    load_lengths();
    send_bit(1'b1); send_bit(1'b1);
    lens_q = '{8'd2, 8'd2, 8'd2, 8'd2};  // length item drops the partial code
    load_lengths();
    send_bit(1'b1); send_bit(1'b1);
    send_bit(1'b0); send_bit(1'b0);
  endtask

  task automatic test_overflow();
    // more entries than the store holds; extras are ignored but the mark counts
    make_lengths(NSYM + 3, MAXBITS, 1'b0);
    load_lengths();
    random_bits(40);
    wait_results();
  endtask

  task automatic test_backpressure();
    make_lengths(6, 3, 1'b0);
    load_lengths();
    wait_results();
    receiver_hold = 300;
    sender_idle_on = 1'b0;
    random_bits(40);
    sender_idle_on = 1'b1;
    wait_results();
  endtask

  task automatic test_random();
    int pick;
    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      receiver_idle_on = ($urandom_range(0, 9) != 0);
      sender_idle_on = ($urandom_range(0, 9) != 0);
      if (pick < 80) begin
        make_lengths($urandom_range(2, 24), $urandom_range(1, MAXBITS), 1'($urandom));
        load_lengths();
        random_bits($urandom_range(10, 50));
      end else if (pick < 88) begin
        make_lengths($urandom_range(3, 12), MAXBITS, 1'b1);
        lens_q[$urandom_range(0, lens_q.size() - 1)] = 8'($urandom_range(16, 255));
        load_lengths();
        random_bits($urandom_range(1, 4));
      end else if (pick < 93) begin
        make_lengths($urandom_range(3, 10), MAXBITS, 1'b0);
        lens_q[0] = 8'd1; lens_q[1] = 8'd1; lens_q[2] = 8'd1;
        load_lengths();
      end else if (pick < 98) begin
        // broken load: stray bits, then an unmarked length that joins the front of the list
        make_lengths($urandom_range(2, 8), MAXBITS, 1'b0);
        random_bits($urandom_range(1, 3));
        send_item(1'b0, 8'($urandom), 1'b0, 1'($urandom));
        load_lengths();
        random_bits($urandom_range(1, 10));
      end else begin
        make_lengths(NSYM, MAXBITS, 1'($urandom));
        load_lengths();
        random_bits(60);
      end
    end
    receiver_idle_on = 1'b1;
    sender_idle_on = 1'b1;
  endtask

  // ---------------- result side ----------------
  initial begin : result_checker
    int stall;
    result_t want;
    @(posedge rst_n);
    forever begin
      if (receiver_hold > 0) begin
        pop <= 1'b0;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
      end else begin
        stall = receiver_idle_on ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d symbol=%0d", status, symbol));
      end else begin
        want = pending_q.pop_front();
        if (status !== want.status)
          report($sformatf("status got %0d want %0d", status, want.status));
        if (symbol !== want.symbol)
          report($sformatf("symbol got %0d want %0d", symbol, want.symbol));
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    for (int b = 0; b <= MAXBITS; b++) len_hist[b] = 0;
    load_idx = 0; saw_bad_len = 1'b0; tbl_ok = 1'b0;
    clear_walk();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_small_tables();
    test_rejects();
    test_abort_and_long();
    test_overflow();
    test_backpressure();
    test_random();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
